>>> design/ssd_pkg.sv
// Shared types, constants and the digit pattern table of the signed integer
// to seven-segment converter. Used by every module of the design folder.
// Depends on nothing.
package ssd_pkg;

	localparam int NUM_W   = 16;
	localparam int MAG_W   = 14;
	localparam int DIGIT_W = 4;
	localparam int SEG_W   = 7;
	localparam int POS_N   = 4;
	localparam int DATA_W  = 32;

	localparam logic signed [NUM_W-1:0] SHOW_MAX = 16'sd9999;
	localparam logic signed [NUM_W-1:0] SHOW_MIN = -16'sd999;
	localparam logic [MAG_W-1:0] MAG_MAX_POS = 14'd9999;
	localparam logic [MAG_W-1:0] MAG_MAX_NEG = 14'd999;

	// Reciprocal multipliers; each quotient is exact for magnitudes up to 9999.
	localparam logic [13:0] RECIP_1000 = 14'd8389;
	localparam int          SHIFT_1000 = 23;
	localparam logic [12:0] RECIP_100  = 13'd5243;
	localparam int          SHIFT_100  = 19;
	localparam logic [15:0] RECIP_10   = 16'd52429;
	localparam int          SHIFT_10   = 19;

	localparam logic [SEG_W-1:0] SEG_MINUS = 7'h40;
	localparam logic [SEG_W-1:0] SEG_BLANK = 7'h00;
	localparam logic [SEG_W-1:0] SEG_NINE  = 7'h6F;

	typedef logic [DIGIT_W-1:0] digit_t;
	typedef logic [SEG_W-1:0]   seg_t;

	// Decimal digits of the clamped magnitude, with the sign and clip flags.
	typedef struct packed {
		logic   neg;
		logic   clipped;
		digit_t thousands;
		digit_t hundreds;
		digit_t tens;
		digit_t units;
	} digits_t;

	function automatic seg_t seg_of_digit(input digit_t d);
		seg_t s;
		case (d)
			4'd0: s = 7'h3F;
			4'd1: s = 7'h06;
			4'd2: s = 7'h5B;
			4'd3: s = 7'h4F;
			4'd4: s = 7'h66;
			4'd5: s = 7'h6D;
			4'd6: s = 7'h7D;
			4'd7: s = 7'h07;
			4'd8: s = 7'h7F;
			4'd9: s = 7'h6F;
			default: s = SEG_BLANK;
		endcase
		return s;
	endfunction

endpackage

>>> design/ssd_split.sv
// Clamps the signed input to the showable range and splits its magnitude into
// four decimal digits with reciprocal multiplications. Uses ssd_pkg.
module ssd_split (
	input  logic [ssd_pkg::NUM_W-1:0] number,
	output ssd_pkg::digits_t          digits
);

	logic                        neg;
	logic                        clip_hi;
	logic                        clip_lo;
	logic [ssd_pkg::NUM_W-1:0]   negated;
	logic [ssd_pkg::MAG_W-1:0]   mag;
	logic [27:0]                 prod_1000;
	logic [26:0]                 prod_100;
	logic [29:0]                 prod_10;
	logic [3:0]                  q1000;
	logic [6:0]                  q100;
	logic [9:0]                  q10;
	logic [6:0]                  h_full;
	logic [9:0]                  t_full;
	logic [ssd_pkg::MAG_W-1:0]   u_full;

	assign neg     = number[ssd_pkg::NUM_W-1];
	assign clip_hi = $signed(number) > ssd_pkg::SHOW_MAX;
	assign clip_lo = $signed(number) < ssd_pkg::SHOW_MIN;
	assign negated = -number;

	always_comb begin
		if (clip_hi) begin
			mag = ssd_pkg::MAG_MAX_POS;
		end else if (clip_lo) begin
			mag = ssd_pkg::MAG_MAX_NEG;
		end else if (neg) begin
			mag = negated[ssd_pkg::MAG_W-1:0];
		end else begin
			mag = number[ssd_pkg::MAG_W-1:0];
		end
	end

	// The three quotients are formed side by side; the thousands digit is q1000 and each
	// other digit is one quotient, or mag for units, less ten times the next coarser one.
	assign prod_1000 = 28'(mag) * 28'(ssd_pkg::RECIP_1000);
	assign prod_100  = 27'(mag) * 27'(ssd_pkg::RECIP_100);
	assign prod_10   = 30'(mag) * 30'(ssd_pkg::RECIP_10);

	assign q1000 = prod_1000[ssd_pkg::SHIFT_1000 +: 4];
	assign q100  = prod_100[ssd_pkg::SHIFT_100 +: 7];
	assign q10   = prod_10[ssd_pkg::SHIFT_10 +: 10];

	assign h_full = q100 - 7'(q1000) * 7'd10;
	assign t_full = q10 - 10'(q100) * 10'd10;
	assign u_full = mag - 14'(q10) * 14'd10;

	assign digits.neg       = neg;
	assign digits.clipped   = clip_hi | clip_lo;
	assign digits.thousands = q1000;
	assign digits.hundreds  = h_full[3:0];
	assign digits.tens      = t_full[3:0];
	assign digits.units     = u_full[3:0];

endmodule

>>> design/ssd_encode.sv
// Turns four decimal digits into segment patterns, blanking leading zeros and
// placing the minus sign left of the first shown digit. Uses ssd_pkg.
module ssd_encode (
	input  ssd_pkg::digits_t digits,
	output ssd_pkg::seg_t    seg_left,
	output ssd_pkg::seg_t    seg_second,
	output ssd_pkg::seg_t    seg_third,
	output ssd_pkg::seg_t    seg_right
);

	logic show_left;
	logic show_second;
	logic show_third;

	assign show_left   = digits.thousands != '0;
	assign show_second = show_left | (digits.hundreds != '0);
	assign show_third  = show_second | (digits.tens != '0);

	always_comb begin
		if (show_left) begin
			seg_left = ssd_pkg::seg_of_digit(digits.thousands);
		end else if (digits.neg && show_second) begin
			seg_left = ssd_pkg::SEG_MINUS;
		end else begin
			seg_left = ssd_pkg::SEG_BLANK;
		end

		if (show_second) begin
			seg_second = ssd_pkg::seg_of_digit(digits.hundreds);
		end else if (digits.neg && show_third) begin
			seg_second = ssd_pkg::SEG_MINUS;
		end else begin
			seg_second = ssd_pkg::SEG_BLANK;
		end

		// The units digit is always shown, and for a negative value the tens place
		// is at least the minus sign.
		if (show_third) begin
			seg_third = ssd_pkg::seg_of_digit(digits.tens);
		end else if (digits.neg) begin
			seg_third = ssd_pkg::SEG_MINUS;
		end else begin
			seg_third = ssd_pkg::SEG_BLANK;
		end
	end

	assign seg_right = ssd_pkg::seg_of_digit(digits.units);

endmodule

>>> design/signed_int_to_seven_segment.sv
// Top level of the signed integer to four-digit seven-segment converter.
// Input register, ssd_split and ssd_encode, then the result register. Uses ssd_pkg.
//
// Channel   Dir  Payload
// s_*       in   tdata[15:0] number_in (signed)
// m_*       out  tdata[27:0] four segment patterns, tuser[0] clipped
//
// An accepted request passes through the input register, the combinational
// conversion and then the result register to m_*. One request is taken every
// cycle while m_* is not stalled; the input register still fills behind a stall.
// Reset empties both registers. A stall on m_tready holds the result and
// backs up into s_tready only once both registers are full.
module signed_int_to_seven_segment (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [15:0] s_tdata,   // [15:0] number_in
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [31:0] m_tdata,   // [6:0] digit_left, [13:7] digit_second,
	                               // [20:14] digit_third, [27:21] digit_right,
	                               // [31:28] zero
	output logic [0:0]  m_tuser    // [0] clipped
);

	logic                          valid_s1;
	logic [ssd_pkg::NUM_W-1:0]     number_s1;
	logic                          valid_s2;
	logic [ssd_pkg::DATA_W-1:0]    data_s2;
	logic                          clipped_s2;
	logic                          load_s2;
	logic                          load_s1;
	ssd_pkg::digits_t              digits;
	ssd_pkg::seg_t                 seg_left;
	ssd_pkg::seg_t                 seg_second;
	ssd_pkg::seg_t                 seg_third;
	ssd_pkg::seg_t                 seg_right;

	assign load_s2  = !valid_s2 || m_tready;
	assign s_tready = !valid_s1 || load_s2;
	assign load_s1  = s_tvalid && s_tready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_tready) begin
			valid_s1 <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (load_s1) begin
			number_s1 <= s_tdata;
		end
	end

	ssd_split u_split (
		.number (number_s1),
		.digits (digits)
	);

	ssd_encode u_encode (
		.digits     (digits),
		.seg_left   (seg_left),
		.seg_second (seg_second),
		.seg_third  (seg_third),
		.seg_right  (seg_right)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (load_s2) begin
			valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (load_s2 && valid_s1) begin
			data_s2    <= {4'b0000, seg_right, seg_third, seg_second, seg_left};
			clipped_s2 <= digits.clipped;
		end
	end

	assign m_tvalid   = valid_s2;
	assign m_tdata    = data_s2;
	assign m_tuser[0] = clipped_s2;

endmodule

>>> design/ssd_checker.sv
// Port-level checks for signed_int_to_seven_segment, attached by bind.
// Uses ssd_pkg for the segment codes.
module ssd_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        s_tvalid,
	input logic        s_tready,
	input logic        m_tvalid,
	input logic        m_tready,
	input logic [31:0] m_tdata,
	input logic [0:0]  m_tuser
);

	// A stalled result stays put.
	assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
		else $error("result changed while stalled");

	// Every accepted request is followed by a valid output, either its own result
	// or an older stalled result that is still waiting there.
	assert property (@(posedge clk) disable iff (!arst_n)
		s_tvalid && s_tready |-> ##2 m_tvalid)
		else $error("request not carried to the output");

	// The units position is never blank and the padding bits are zero.
	assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> m_tdata[27:21] != ssd_pkg::SEG_BLANK && m_tdata[31:28] == 4'b0000)
		else $error("units blank or padding set");

	// A clipped result reads 9999 or -999.
	assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tuser[0] |->
			m_tdata[27:21] == ssd_pkg::SEG_NINE && m_tdata[20:14] == ssd_pkg::SEG_NINE &&
			m_tdata[13:7] == ssd_pkg::SEG_NINE &&
			(m_tdata[6:0] == ssd_pkg::SEG_NINE || m_tdata[6:0] == ssd_pkg::SEG_MINUS))
		else $error("clipped result is not a limit value");

endmodule

bind signed_int_to_seven_segment ssd_checker u_ssd_checker (.*);
